// ===== src/ofw_pkg.sv =====
// ofw_pkg: shared types, register indexes and constants of the overlapped frame windower
// no dependencies; used by ofw_ctrl, ofw_dp and overlapped_frame_windower
`default_nettype none

package ofw_pkg;

   // fixed field widths
   localparam int POS_W      = 6;
   localparam int LEN_W      = 7;
   localparam int HOP_W      = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LEN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOP       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_EN    = 2'd2;

   // request kinds
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_LOAD   = 1'b1;

   // reset values of the registers
   localparam logic [LEN_W-1:0] FRAME_LEN_RST = 7'd64;
   localparam logic [HOP_W-1:0] HOP_RST       = 10'd32;
   localparam logic             WIN_EN_RST    = 1'b1;

   // output queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   // controller to datapath commands
   typedef struct packed {
      logic             ring_we;
      logic             table_we;
      logic [POS_W-1:0] wr_addr;
      logic             rd_en;
      logic [POS_W-1:0] ring_raddr;
      logic [POS_W-1:0] pos;
      logic             last;
      logic             win_en;
   } cmd_type;

   // effective frame length: zero acts as one, above the maximum acts as the maximum
   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v,
                                                input logic [LEN_W-1:0] maxv);
      logic [LEN_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = 7'd1;
      end else if (v > maxv) begin
         r = maxv;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/overlapped_frame_windower.sv =====
// overlapped_frame_windower: top level, splits framing into controller and datapath
// depends on ofw_pkg, ofw_ctrl, ofw_dp (and ofw_ram through ofw_dp)
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_type, req_sample_in, req_coef_index,
//                                             req_coef_value
// rsp       out        rsp_valid / rsp_ready  rsp_frame_value, rsp_frame_pos, rsp_frame_last
// csr       in         csr_we                 csr_index, csr_wdata
//
// a load or a sample that completes no frame leaves the block ready for the next request
// a frame-completing sample holds off requests while the sequencer walks the single read
// port of sample ring and window table, one element a cycle while the queue has room
// elements pass through the ram read registers and the product register into the queue
// rsp stalls back up through a four entry output queue and pause the frame reads
// reset is synchronous; ring and window table are not cleared and need no clearing pass

module overlapped_frame_windower #(
   parameter int MAX_FRAME   = 64,
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,

   // configuration writes
   input  wire logic                             csr_we,
   input  wire logic [ofw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ofw_pkg::CSR_DATA_W-1:0]   csr_wdata,

   // sample and coefficient load transactions
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_type,
   input  wire logic signed [SAMPLE_BITS-1:0]    req_sample_in,
   input  wire logic        [ofw_pkg::POS_W-1:0] req_coef_index,
   input  wire logic        [COEF_BITS-1:0]      req_coef_value,

   // frame element transactions
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_frame_value,
   output logic        [ofw_pkg::POS_W-1:0]      rsp_frame_pos,
   output logic                                  rsp_frame_last
);

   // command bundle from sequencer to datapath, and the queue credit back
   ofw_pkg::cmd_type cmd;
   logic             credit_ok;

   // controller: registers, write pointer, samples-due counter, frame read sequencer
   ofw_ctrl #(
      .MAX_FRAME (MAX_FRAME)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_coef_index (req_coef_index),
      .credit_ok      (credit_ok),
      .cmd            (cmd)
   );

   // datapath: ring and table rams, multiply, round and saturate, output queue
   ofw_dp #(
      .MAX_FRAME   (MAX_FRAME),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .credit_ok       (credit_ok),
      .req_sample_in   (req_sample_in),
      .req_coef_value  (req_coef_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_value (rsp_frame_value),
      .rsp_frame_pos   (rsp_frame_pos),
      .rsp_frame_last  (rsp_frame_last)
   );

endmodule

`default_nettype wire

// ===== src/ofw_ram.sv =====
// ofw_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ofw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== src/ofw_ctrl.sv =====
// ofw_ctrl: configuration registers, framing counters and frame read sequencer
// depends on ofw_pkg
`default_nettype none

module ofw_ctrl #(
   parameter int MAX_FRAME = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [ofw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ofw_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_type,
   input  wire logic [ofw_pkg::POS_W-1:0]        req_coef_index,
   input  wire logic                             credit_ok,
   output ofw_pkg::cmd_type                      cmd
);

   localparam int AW = $clog2(MAX_FRAME);
   localparam logic [ofw_pkg::LEN_W-1:0] MAX_LEN = ofw_pkg::LEN_W'(MAX_FRAME);
   localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_FRAME - 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type                         state_ff, state_in;
   logic [ofw_pkg::LEN_W-1:0]         frame_len_ff, frame_len_in;
   logic [ofw_pkg::HOP_W-1:0]         hop_ff, hop_in;
   logic                              win_ff, win_in;
   logic [AW-1:0]                     wp_ff, wp_in;
   logic [ofw_pkg::HOP_W-1:0]         due_ff, due_in;
   logic [AW-1:0]                     rd_ptr_ff, rd_ptr_in;
   logic [ofw_pkg::POS_W-1:0]         pos_ff, pos_in;

   logic [ofw_pkg::LEN_W-1:0]         len_eff;
   logic [ofw_pkg::HOP_W-1:0]         hop_eff;
   logic [AW-1:0]                     wp_nxt;
   logic [AW-1:0]                     rd_ptr_nxt;
   logic [ofw_pkg::LEN_W-1:0]         diff;
   logic [ofw_pkg::LEN_W-1:0]         start;
   logic                              elem_last;

   assign len_eff    = ofw_pkg::eff_len(frame_len_ff, MAX_LEN);
   assign hop_eff    = (hop_ff == '0) ? ofw_pkg::HOP_W'(1) : hop_ff;
   assign wp_nxt     = (wp_ff == LAST_SLOT) ? '0 : wp_ff + 1'b1;
   assign rd_ptr_nxt = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
   // oldest slot of the frame that ends with the sample now being written
   assign diff       = ofw_pkg::LEN_W'(wp_nxt) + MAX_LEN - len_eff;
   assign start      = (diff >= MAX_LEN) ? diff - MAX_LEN : diff;
   assign elem_last  = (ofw_pkg::LEN_W'(pos_ff) + 7'd1) == len_eff;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      frame_len_in = frame_len_ff;
      hop_in       = hop_ff;
      win_in       = win_ff;
      wp_in        = wp_ff;
      due_in       = due_ff;
      rd_ptr_in    = rd_ptr_ff;
      pos_in       = pos_ff;
      cmd          = '0;
      cmd.win_en   = win_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_type == ofw_pkg::REQ_LOAD) begin
                  cmd.table_we = ofw_pkg::LEN_W'(req_coef_index) < MAX_LEN;
                  cmd.wr_addr  = req_coef_index;
               end else begin
                  cmd.ring_we = 1'b1;
                  cmd.wr_addr = ofw_pkg::POS_W'(wp_ff);
                  wp_in       = wp_nxt;
                  if (due_ff > ofw_pkg::HOP_W'(1)) begin
                     due_in = due_ff - 1'b1;
                  end else begin
                     due_in    = hop_eff;
                     rd_ptr_in = start[AW-1:0];
                     pos_in    = '0;
                     state_in  = ST_EMIT;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (credit_ok) begin
               cmd.rd_en      = 1'b1;
               cmd.ring_raddr = ofw_pkg::POS_W'(rd_ptr_ff);
               cmd.pos        = pos_ff;
               cmd.last       = elem_last;
               rd_ptr_in      = rd_ptr_nxt;
               pos_in         = pos_ff + 1'b1;
               if (elem_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         unique case (csr_index)
            ofw_pkg::CSR_FRAME_LEN: begin
               frame_len_in = csr_wdata[ofw_pkg::LEN_W-1:0];
               due_in = ofw_pkg::HOP_W'(ofw_pkg::eff_len(csr_wdata[ofw_pkg::LEN_W-1:0],
                                                         MAX_LEN));
            end
            ofw_pkg::CSR_HOP: begin
               hop_in = csr_wdata;
            end
            ofw_pkg::CSR_WIN_EN: begin
               win_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frame_len_ff <= ofw_pkg::FRAME_LEN_RST;
         hop_ff       <= ofw_pkg::HOP_RST;
         win_ff       <= ofw_pkg::WIN_EN_RST;
         wp_ff        <= '0;
         due_ff       <= ofw_pkg::HOP_W'(ofw_pkg::eff_len(ofw_pkg::FRAME_LEN_RST, MAX_LEN));
         rd_ptr_ff    <= '0;
         pos_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         frame_len_ff <= frame_len_in;
         hop_ff       <= hop_in;
         win_ff       <= win_in;
         wp_ff        <= wp_in;
         due_ff       <= due_in;
         rd_ptr_ff    <= rd_ptr_in;
         pos_ff       <= pos_in;
      end
   end

`ifndef SYNTHESIS
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (ofw_pkg::LEN_W'(pos_ff) < len_eff))
      else $error("frame position beyond frame length");

   a_frame_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == ofw_pkg::REQ_SAMPLE
       && due_ff == ofw_pkg::HOP_W'(1)) |=> (state_ff == ST_EMIT && pos_ff == '0))
      else $error("completing sample did not start a frame");
`endif

endmodule

`default_nettype wire

// ===== src/ofw_dp.sv =====
// ofw_dp: sample ring, window table, weighting pipeline and output queue
// depends on ofw_pkg and ofw_ram
`default_nettype none

module ofw_dp #(
   parameter int MAX_FRAME   = 64,
   parameter int SAMPLE_BITS = 16,
   parameter int COEF_BITS   = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire ofw_pkg::cmd_type                 cmd,
   output logic                                  credit_ok,
   input  wire logic signed [SAMPLE_BITS-1:0]    req_sample_in,
   input  wire logic        [COEF_BITS-1:0]      req_coef_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_frame_value,
   output logic        [ofw_pkg::POS_W-1:0]      rsp_frame_pos,
   output logic                                  rsp_frame_last
);

   localparam int AW = $clog2(MAX_FRAME);
   localparam int PW = SAMPLE_BITS + COEF_BITS + 1;
   localparam int QW = SAMPLE_BITS + 2;

   logic        [SAMPLE_BITS-1:0]   ring_rdata;
   logic        [COEF_BITS-1:0]     table_rdata;
   logic signed [SAMPLE_BITS-1:0]   samp_s1;
   logic signed [COEF_BITS:0]       coef_s1;

   logic                            s1_v_ff, s1_v_in;
   logic [ofw_pkg::POS_W-1:0]       s1_pos_ff;
   logic                            s1_last_ff;
   logic                            s1_win_ff;

   logic                            s2_v_ff, s2_v_in;
   logic [ofw_pkg::POS_W-1:0]       s2_pos_ff;
   logic                            s2_last_ff;
   logic signed [PW-1:0]            prod_ff, prod_in;

   logic signed [PW:0]              rsum;
   logic signed [QW-1:0]            q;
   logic signed [SAMPLE_BITS-1:0]   sat;

   logic signed [SAMPLE_BITS-1:0]   q_value_ff [ofw_pkg::FIFO_DEPTH];
   logic [ofw_pkg::POS_W-1:0]       q_pos_ff   [ofw_pkg::FIFO_DEPTH];
   logic                            q_last_ff  [ofw_pkg::FIFO_DEPTH];
   logic [ofw_pkg::FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [ofw_pkg::FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [ofw_pkg::FIFO_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ofw_pkg::FIFO_CNT_W-1:0]  occupancy;
   logic                            push, pop;

   ofw_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_FRAME)
   ) u_ring (
      .clock (clock),
      .we    (cmd.ring_we),
      .waddr (cmd.wr_addr[AW-1:0]),
      .wdata (req_sample_in),
      .re    (cmd.rd_en),
      .raddr (cmd.ring_raddr[AW-1:0]),
      .rdata (ring_rdata)
   );

   ofw_ram #(
      .WIDTH (COEF_BITS),
      .DEPTH (MAX_FRAME)
   ) u_table (
      .clock (clock),
      .we    (cmd.table_we),
      .waddr (cmd.wr_addr[AW-1:0]),
      .wdata (req_coef_value),
      .re    (cmd.rd_en),
      .raddr (cmd.pos[AW-1:0]),
      .rdata (table_rdata)
   );

   assign samp_s1 = ring_rdata;
   assign coef_s1 = {1'b0, table_rdata};

   // unweighted samples go through as sample * 2^COEF_BITS, which rounds back exactly
   always_comb begin
      if (s1_win_ff) begin
         prod_in = samp_s1 * coef_s1;
      end else begin
         prod_in = PW'(samp_s1) <<< COEF_BITS;
      end
   end

   // round half up, floor shift, saturate
   assign rsum = {prod_ff[PW-1], prod_ff}
               + {{(PW+1-COEF_BITS){1'b0}}, 1'b1, {(COEF_BITS-1){1'b0}}};
   assign q    = rsum[PW:COEF_BITS];

   always_comb begin
      if (q[QW-1:SAMPLE_BITS-1] == '0 || q[QW-1:SAMPLE_BITS-1] == '1) begin
         sat = q[SAMPLE_BITS-1:0];
      end else if (q[QW-1]) begin
         sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   assign push      = s2_v_ff;
   assign pop       = rsp_valid && rsp_ready;
   assign s1_v_in   = cmd.rd_en;
   assign s2_v_in   = s1_v_ff;
   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign cnt_in    = cnt_ff + ofw_pkg::FIFO_CNT_W'(push) - ofw_pkg::FIFO_CNT_W'(pop);

   // every element in flight has a queue slot reserved for it
   assign occupancy = ofw_pkg::FIFO_CNT_W'(s1_v_ff) + ofw_pkg::FIFO_CNT_W'(s2_v_ff) + cnt_ff;
   assign credit_ok = occupancy < ofw_pkg::FIFO_CNT_W'(ofw_pkg::FIFO_DEPTH);

   assign rsp_valid       = (cnt_ff != '0);
   assign rsp_frame_value = q_value_ff[rd_ptr_ff];
   assign rsp_frame_pos   = q_pos_ff[rd_ptr_ff];
   assign rsp_frame_last  = q_last_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         s1_v_ff   <= s1_v_in;
         s2_v_ff   <= s2_v_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pos_ff  <= cmd.pos;
      s1_last_ff <= cmd.last;
      s1_win_ff  <= cmd.win_en;
      s2_pos_ff  <= s1_pos_ff;
      s2_last_ff <= s1_last_ff;
      prod_ff    <= prod_in;
      if (push) begin
         q_value_ff[wr_ptr_ff] <= sat;
         q_pos_ff[wr_ptr_ff]   <= s2_pos_ff;
         q_last_ff[wr_ptr_ff]  <= s2_last_ff;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && cnt_ff == ofw_pkg::FIFO_CNT_W'(ofw_pkg::FIFO_DEPTH)))
      else $error("output queue overflow");

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      occupancy <= ofw_pkg::FIFO_CNT_W'(ofw_pkg::FIFO_DEPTH))
      else $error("more elements in flight than queue slots");

   a_read_has_credit: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> credit_ok)
      else $error("frame read issued without a free queue slot");
`endif

endmodule

`default_nettype wire

// ===== tb/overlapped_frame_windower_tb.sv =====
// overlapped_frame_windower_tb: self-checking testbench for the overlapped frame windower
// predicts every frame element from its own model of the ring, window table and registers
// depends on ofw_pkg and the rtl under src/ only; random values come from the simulator seed

module overlapped_frame_windower_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // block configuration under test
   localparam int MAXF = 64;
   localparam int SB   = 16;
   localparam int CB   = 16;

   // register index past the end of the list, written to check it is ignored
   localparam logic [ofw_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // cycles to let pass once the last element is in
   localparam int TAIL_CYCLES = 8;
   // generous ceiling on the whole run
   localparam int LIMIT = 4000000;
   // items for the random settings, on top of the directed tests
   localparam int RANDOM_ITEMS = 36;

   // one frame element as it leaves the block
   typedef struct packed {
      logic signed [SB-1:0]      value;
      logic [ofw_pkg::POS_W-1:0] pos;
      logic                      last;
   } frame_elem_type;

   // ------------------------------------------------------------------
   // block ports, every input known from time zero
   // ------------------------------------------------------------------
   logic                            clock;
   logic                            reset = 1'b1;
   logic                            csr_we = 1'b0;
   logic [ofw_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [ofw_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic                            req_type = ofw_pkg::REQ_SAMPLE;
   logic signed [SB-1:0]            req_sample_in = '0;
   logic [ofw_pkg::POS_W-1:0]       req_coef_index = '0;
   logic [CB-1:0]                   req_coef_value = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic signed [SB-1:0]            rsp_frame_value;
   logic [ofw_pkg::POS_W-1:0]       rsp_frame_pos;
   logic                            rsp_frame_last;

   overlapped_frame_windower #(
      .MAX_FRAME   (MAXF),
      .SAMPLE_BITS (SB),
      .COEF_BITS   (CB)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_sample_in   (req_sample_in),
      .req_coef_index  (req_coef_index),
      .req_coef_value  (req_coef_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_value (rsp_frame_value),
      .rsp_frame_pos   (rsp_frame_pos),
      .rsp_frame_last  (rsp_frame_last)
   );

   // ------------------------------------------------------------------
   // predictor state: sample history, window table and register copies
   // ------------------------------------------------------------------
   logic signed [SB-1:0]      sample_hist [MAXF];
   logic [CB-1:0]             coef_table [MAXF];
   logic [ofw_pkg::POS_W-1:0] next_slot;
   logic [ofw_pkg::HOP_W-1:0] samples_to_frame;
   logic [ofw_pkg::LEN_W-1:0] cur_frame_len;
   logic [ofw_pkg::HOP_W-1:0] cur_hop;
   logic                      cur_win_en;

   // frame elements still owed by the block, oldest first
   frame_elem_type pending_elems [$];

   // shared between stimulus, receiver and checker
   bit quiet;            // no idling on either side while set
   int hold_cycles;      // long receiver hold-off requested by a test
   bit rsp_holding;      // receiver is in that hold-off
   int cycle_count;
   int mismatches;
   int n_checked;
   int n_frames;
   int n_samples;
   int n_loads;
   int n_settings;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // frame length as the block applies it: zero acts as one, past the maximum as the maximum
   function automatic int frame_elems(input logic [ofw_pkg::LEN_W-1:0] v);
      int n;
      n = int'(v);
      if (n == 0) begin
         n = 1;
      end else if (n > MAXF) begin
         n = MAXF;
      end
      return n;
   endfunction

   // sample times Q0.16 coefficient, rounded half up by floor shift, saturated
   function automatic logic signed [SB-1:0] weigh_sample(input logic signed [SB-1:0] s,
                                                         input logic [CB-1:0] c);
      longint acc;
      longint q;
      longint hi;
      hi  = (longint'(1) << (SB - 1)) - 1;
      acc = longint'(s) * longint'({1'b0, c}) + (longint'(1) << (CB - 1));
      q   = acc >>> CB;
      if (q > hi) begin
         q = hi;
      end else if (q < -hi - 1) begin
         q = -hi - 1;
      end
      return q[SB-1:0];
   endfunction

   // take one accepted transaction into the model and queue the frame it completes
   task automatic predict_frame(input logic kind, input logic signed [SB-1:0] smp,
                                input logic [ofw_pkg::POS_W-1:0] idx,
                                input logic [CB-1:0] coef);
      int                        len;
      logic [ofw_pkg::POS_W-1:0] first;
      logic [ofw_pkg::POS_W-1:0] slot;
      frame_elem_type            elem;
      if (kind == ofw_pkg::REQ_LOAD) begin
         coef_table[idx] = coef;
         n_loads++;
      end else begin
         n_samples++;
         sample_hist[next_slot] = smp;
         next_slot++;
         if (samples_to_frame > 1) begin
            samples_to_frame--;
         end else begin
            // frame due: reload the countdown from hop and emit oldest first
            samples_to_frame = (cur_hop == '0) ? ofw_pkg::HOP_W'(1) : cur_hop;
            len   = frame_elems(cur_frame_len);
            first = next_slot - ofw_pkg::POS_W'(len);
            for (int j = 0; j < len; j++) begin
               slot       = first + ofw_pkg::POS_W'(j);
               elem.value = cur_win_en ? weigh_sample(sample_hist[slot], coef_table[j])
                                       : sample_hist[slot];
               elem.pos   = ofw_pkg::POS_W'(j);
               elem.last  = (j == len - 1);
               pending_elems.push_back(elem);
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // idling
   // ------------------------------------------------------------------

   // mostly none or short, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // receiver: random ready pattern plus the long hold-off on request
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rsp_holding = 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
            rsp_holding = 1'b0;
         end else if (quiet || $urandom_range(0, 99) < 65) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------
   // checking of frame element transactions
   // ------------------------------------------------------------------
   function automatic void log_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      end
   endfunction

   always @(posedge clock) begin
      frame_elem_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         n_checked++;
         if (pending_elems.size() == 0) begin
            log_mismatch($sformatf("unexpected element value %0d pos %0d last %0b",
                                   rsp_frame_value, rsp_frame_pos, rsp_frame_last));
         end else begin
            want = pending_elems.pop_front();
            if (rsp_frame_value !== want.value || rsp_frame_pos !== want.pos ||
                rsp_frame_last !== want.last) begin
               log_mismatch($sformatf(
                  "expected value %0d pos %0d last %0b, got value %0d pos %0d last %0b",
                  want.value, want.pos, want.last,
                  rsp_frame_value, rsp_frame_pos, rsp_frame_last));
            end
            if (want.last) begin
               n_frames++;
            end
         end
      end
   end

   // run limit
   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles with %0d elements outstanding",
               cycle_count, pending_elems.size());
      $display("Regression FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // shared stimulus tasks
   // ------------------------------------------------------------------

   // offer one transaction after a random gap; valid stays up into the next one
   task automatic send_item(input logic kind, input logic signed [SB-1:0] smp,
                            input logic [ofw_pkg::POS_W-1:0] idx, input logic [CB-1:0] coef);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_sample_in  <= smp;
      req_coef_index <= idx;
      req_coef_value <= coef;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_frame(kind, smp, idx, coef);
   endtask

   // unused fields carry random bits
   task automatic send_sample(input logic signed [SB-1:0] smp);
      send_item(ofw_pkg::REQ_SAMPLE, smp, ofw_pkg::POS_W'($urandom), CB'($urandom));
   endtask

   task automatic send_load(input logic [ofw_pkg::POS_W-1:0] idx, input logic [CB-1:0] coef);
      send_item(ofw_pkg::REQ_LOAD, SB'($urandom), idx, coef);
   endtask

   // random sample, now and then a full-scale or near-zero one
   function automatic logic signed [SB-1:0] rand_sample();
      logic signed [SB-1:0] v;
      v = SB'($urandom);
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: v = {1'b1, {(SB-1){1'b0}}};
            1: v = {1'b0, {(SB-1){1'b1}}};
            2: v = '0;
            default: v = '1;
         endcase
      end
      return v;
   endfunction

   // register write, only ever issued with the block idle
   task automatic write_reg(input logic [ofw_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ofw_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         ofw_pkg::CSR_FRAME_LEN: begin
            // a length write restarts framing
            cur_frame_len    = data[ofw_pkg::LEN_W-1:0];
            samples_to_frame = ofw_pkg::HOP_W'(frame_elems(cur_frame_len));
         end
         ofw_pkg::CSR_HOP:    cur_hop = data[ofw_pkg::HOP_W-1:0];
         ofw_pkg::CSR_WIN_EN: cur_win_en = data[0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering, wait for every owed element, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_elems.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // fill the whole window table so no frame can read an unwritten entry
   task automatic test_coef_load();
      logic [CB-1:0] c;
      for (int i = 0; i < MAXF; i++) begin
         case (i)
            0: c = '1;                       // full-scale coefficient
            1: c = '0;
            2: c = {1'b1, {(CB-1){1'b0}}};   // one half
            3: c = CB'(1);
            default: c = CB'($urandom);
         endcase
         send_load(ofw_pkg::POS_W'(i), c);
      end
      // overwrite a couple of entries
      repeat (2) send_load(ofw_pkg::POS_W'($urandom_range(4, MAXF - 1)), CB'($urandom));
      settle();
   endtask

   // registers as they come out of reset: 64 element frame, window on
   task automatic test_reset_defaults();
      send_sample({1'b1, {(SB-1){1'b0}}});
      send_sample({1'b0, {(SB-1){1'b1}}});
      send_sample('0);
      send_sample('1);
      repeat (MAXF - 4) send_sample(rand_sample());
      settle();
   endtask

   // ignored index, zero length and hop, skipping, pass-through, late hop change
   task automatic test_short_frames();
      n_settings++;
      write_reg(CSR_UNUSED, ofw_pkg::CSR_DATA_W'($urandom));
      write_reg(ofw_pkg::CSR_FRAME_LEN, '0);
      write_reg(ofw_pkg::CSR_HOP, '0);
      send_sample({1'b1, {(SB-1){1'b0}}});
      send_sample({1'b0, {(SB-1){1'b1}}});
      send_sample('1);
      settle();

      // single element frames, hop larger than the frame skips samples
      n_settings++;
      write_reg(ofw_pkg::CSR_FRAME_LEN, ofw_pkg::CSR_DATA_W'(1));
      write_reg(ofw_pkg::CSR_HOP, ofw_pkg::CSR_DATA_W'(3));
      repeat (7) send_sample(rand_sample());
      settle();

      // window off, overlapping frames pass samples unchanged
      n_settings++;
      write_reg(ofw_pkg::CSR_WIN_EN, '0);
      write_reg(ofw_pkg::CSR_FRAME_LEN, ofw_pkg::CSR_DATA_W'(5));
      write_reg(ofw_pkg::CSR_HOP, ofw_pkg::CSR_DATA_W'(2));
      send_sample({1'b1, {(SB-1){1'b0}}});
      send_sample({1'b0, {(SB-1){1'b1}}});
      send_sample('0);
      send_sample('1);
      send_sample(SB'(1));
      repeat (4) send_sample(rand_sample());
      settle();

      // hop change only shows after the frame already counting down
      n_settings++;
      write_reg(ofw_pkg::CSR_HOP, ofw_pkg::CSR_DATA_W'(4));
      repeat (6) send_sample(rand_sample());
      settle();
      write_reg(ofw_pkg::CSR_WIN_EN, ofw_pkg::CSR_DATA_W'(1));
   endtask

   // receiver holds off long enough for the output queue to fill and stall requests
   task automatic test_backpressure();
      n_settings++;
      write_reg(ofw_pkg::CSR_FRAME_LEN, ofw_pkg::CSR_DATA_W'(8));
      write_reg(ofw_pkg::CSR_HOP, ofw_pkg::CSR_DATA_W'(1));
      hold_cycles = 300;
      while (!rsp_holding) @(posedge clock);
      repeat (12) send_sample(rand_sample());
      settle();
   endtask

   // random short-frame settings, mostly sample streams with some table reloads mixed in
   task automatic test_random();
      int                             items;
      int                             len;
      int                             n;
      int                             r;
      logic [ofw_pkg::LEN_W-1:0]      fl;
      logic [ofw_pkg::HOP_W-1:0]      hp;
      logic [ofw_pkg::CSR_DATA_W-1:0] data;
      items = 0;
      while (items < RANDOM_ITEMS) begin
         n_settings++;
         r = $urandom_range(0, 9);
         if (r < 6) begin
            fl = ofw_pkg::LEN_W'($urandom_range(1, 8));
         end else if (r < 9) begin
            fl = ofw_pkg::LEN_W'($urandom_range(9, 16));
         end else begin
            fl = '0;
         end
         if ($urandom_range(0, 4) != 0) begin
            // spare upper data bits are random
            data = ofw_pkg::CSR_DATA_W'($urandom);
            data[ofw_pkg::LEN_W-1:0] = fl;
            write_reg(ofw_pkg::CSR_FRAME_LEN, data);
         end
         len = frame_elems(cur_frame_len);
         r = $urandom_range(0, 9);
         if (r < 6) begin
            hp = ofw_pkg::HOP_W'($urandom_range(1, len + 4));
         end else if (r < 8) begin
            hp = ofw_pkg::HOP_W'($urandom_range(len, 2 * len + 8));
         end else if (r == 8) begin
            hp = '0;
         end else begin
            hp = '1;
         end
         if ($urandom_range(0, 4) != 0) begin
            write_reg(ofw_pkg::CSR_HOP, ofw_pkg::CSR_DATA_W'(hp));
         end
         if ($urandom_range(0, 9) < 7) begin
            data = ofw_pkg::CSR_DATA_W'($urandom);
            write_reg(ofw_pkg::CSR_WIN_EN, data);
         end
         quiet = ($urandom_range(0, 4) == 0);
         // frame length plus a little overlap in items, some of which may be table loads
         n = frame_elems(cur_frame_len) + $urandom_range(2, 8);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               send_load(ofw_pkg::POS_W'($urandom), CB'($urandom));
            end else begin
               send_sample(rand_sample());
            end
         end
         items += n;
         settle();
         quiet = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      // model state as after reset
      next_slot        = '0;
      cur_frame_len    = ofw_pkg::FRAME_LEN_RST;
      cur_hop          = ofw_pkg::HOP_RST;
      cur_win_en       = ofw_pkg::WIN_EN_RST;
      samples_to_frame = ofw_pkg::HOP_W'(frame_elems(ofw_pkg::FRAME_LEN_RST));
      n_settings       = 1;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_coef_load();
      test_reset_defaults();
      test_short_frames();
      test_backpressure();
      test_random();

      $display("run covered %0d samples and %0d coefficient loads over %0d register settings",
               n_samples, n_loads, n_settings);
      $display("%0d frame elements checked in %0d frames, %0d mismatches, %0d cycles",
               n_checked, n_frames, mismatches, cycle_count);
      if (mismatches == 0 && pending_elems.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
